>>> rtl/nipd_pkg.sv
`default_nettype none

package nipd_pkg;

    // Field widths
    localparam int PULSE_W = 20;
    localparam int NOM_W   = 16;
    localparam int GAP_W   = 20;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 6;
    localparam int INDEX_W = 3;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Default frame length in bits
    localparam int FRAME_BITS_DEF = 32;

    // Register reset values
    localparam logic [NOM_W-1:0] TOLERANCE_RST    = 16'd150;
    localparam logic [NOM_W-1:0] HEADER_MARK_RST  = 16'd9000;
    localparam logic [NOM_W-1:0] HEADER_SPACE_RST = 16'd4500;
    localparam logic [NOM_W-1:0] BIT_MARK_RST     = 16'd560;
    localparam logic [NOM_W-1:0] ZERO_SPACE_RST   = 16'd560;
    localparam logic [NOM_W-1:0] ONE_SPACE_RST    = 16'd1690;
    localparam logic [GAP_W-1:0] RESET_GAP_RST    = 20'd13650;

    // Register indexes on the configuration port
    typedef enum logic [INDEX_W-1:0] {
        REG_TOLERANCE    = 3'd0,
        REG_HEADER_MARK  = 3'd1,
        REG_HEADER_SPACE = 3'd2,
        REG_BIT_MARK     = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_ONE_SPACE    = 3'd5,
        REG_RESET_GAP    = 3'd6
    } cfg_index_t;

    // Timing settings seen by the decoder
    typedef struct packed {
        logic [NOM_W-1:0] tolerance_us;
        logic [NOM_W-1:0] header_mark_us;
        logic [NOM_W-1:0] header_space_us;
        logic [NOM_W-1:0] bit_mark_us;
        logic [NOM_W-1:0] zero_space_us;
        logic [NOM_W-1:0] one_space_us;
        logic [GAP_W-1:0] reset_gap_us;
    } cfg_t;

    // One decoded result
    typedef struct packed {
        logic              in_error;
        logic [WORD_W-1:0] frame_data;
        logic              frame_ready;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/nipd_cfg_regs.sv
`default_nettype none

module nipd_cfg_regs
    import nipd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [GAP_W-1:0]   wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;

    // Write one timing register per transfer; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance_us    <= TOLERANCE_RST;
            cfg_reg.header_mark_us  <= HEADER_MARK_RST;
            cfg_reg.header_space_us <= HEADER_SPACE_RST;
            cfg_reg.bit_mark_us     <= BIT_MARK_RST;
            cfg_reg.zero_space_us   <= ZERO_SPACE_RST;
            cfg_reg.one_space_us    <= ONE_SPACE_RST;
            cfg_reg.reset_gap_us    <= RESET_GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_TOLERANCE:    cfg_reg.tolerance_us    <= wr_data[NOM_W-1:0];
                REG_HEADER_MARK:  cfg_reg.header_mark_us  <= wr_data[NOM_W-1:0];
                REG_HEADER_SPACE: cfg_reg.header_space_us <= wr_data[NOM_W-1:0];
                REG_BIT_MARK:     cfg_reg.bit_mark_us     <= wr_data[NOM_W-1:0];
                REG_ZERO_SPACE:   cfg_reg.zero_space_us   <= wr_data[NOM_W-1:0];
                REG_ONE_SPACE:    cfg_reg.one_space_us    <= wr_data[NOM_W-1:0];
                REG_RESET_GAP:    cfg_reg.reset_gap_us    <= wr_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/nipd_core.sv
`default_nettype none

module nipd_core
    import nipd_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               step,
    input  wire logic [PULSE_W-1:0] pulse_us,
    input  wire logic               out_take,
    output logic                    out_free,
    output logic                    out_valid,
    output result_t                 result
);

    typedef enum logic [2:0] {
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_CLOSE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W:0]    count_inc;
    logic                ready_next;
    logic                out_valid_reg;
    result_t             result_reg;
    logic                m_hdr_mark, m_hdr_space, m_bit_mark, m_zero, m_one;
    logic                long_pulse;

    // Strict tolerance window around a nominal duration
    function automatic logic near_match(
        input logic [PULSE_W-1:0] d,
        input logic [NOM_W-1:0]   nominal,
        input logic [NOM_W-1:0]   tol
    );
        logic [PULSE_W-1:0] nom_ext;
        logic [PULSE_W-1:0] diff;
        nom_ext = PULSE_W'(nominal);
        diff    = (d >= nom_ext) ? (d - nom_ext) : (nom_ext - d);
        return diff < PULSE_W'(tol);
    endfunction

    // Compare the pulse against every nominal in parallel
    assign m_hdr_mark  = near_match(pulse_us, cfg.header_mark_us, cfg.tolerance_us);
    assign m_hdr_space = near_match(pulse_us, cfg.header_space_us, cfg.tolerance_us);
    assign m_bit_mark  = near_match(pulse_us, cfg.bit_mark_us, cfg.tolerance_us);
    assign m_zero      = near_match(pulse_us, cfg.zero_space_us, cfg.tolerance_us);
    assign m_one       = near_match(pulse_us, cfg.one_space_us, cfg.tolerance_us);
    assign long_pulse  = pulse_us > cfg.reset_gap_us;

    assign count_inc = {1'b0, count_reg} + 1'b1;

    // Advance the frame walk by one pulse
    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        ready_next = 1'b0;
        if (long_pulse)
        begin
            phase_next = PH_HDR_MARK;
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR_MARK:
                    phase_next = m_hdr_mark ? PH_HDR_SPACE : PH_ERROR;
                PH_HDR_SPACE:
                begin
                    if (m_hdr_space)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = PH_BIT_MARK;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_BIT_MARK:
                    phase_next = m_bit_mark ? PH_BIT_SPACE : PH_ERROR;
                PH_BIT_SPACE:
                begin
                    if (m_zero || m_one)
                    begin
                        // Only the first word of bits is kept
                        if (!count_reg[COUNT_W-1])
                            shift_next[count_reg[COUNT_W-2:0]] = !m_zero;
                        count_next = count_inc[COUNT_W-1:0];
                        phase_next = (count_inc == (COUNT_W+1)'(FRAME_BITS))
                                   ? PH_CLOSE : PH_BIT_MARK;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_CLOSE:
                begin
                    ready_next = 1'b1;
                    phase_next = m_bit_mark ? PH_DONE : PH_ERROR;
                end
                default:
                    phase_next = PH_ERROR;
            endcase
        end
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR_MARK;
            shift_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (step)
            begin
                phase_reg              <= phase_next;
                shift_reg              <= shift_next;
                count_reg              <= count_next;
                out_valid_reg          <= 1'b1;
                result_reg.frame_ready <= ready_next;
                result_reg.frame_data  <= shift_next;
                result_reg.in_error    <= (phase_next == PH_ERROR);
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free  = !out_valid_reg || out_take;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> rtl/nec_ir_pulse_decoder_top.sv
// NEC infrared pulse decoder.
// Slave stream: one measured mark or space duration per transfer, in
// microseconds, saturated at the field maximum. Every pulse gives exactly one
// result on the master stream: frame_ready (closing mark of a full frame),
// frame_data (bits received so far, first bit at bit 0) and in_error.
// Configuration channel: cfg_index selects a timing register (tolerance,
// header mark, header space, bit mark, zero space, one space, reset gap),
// cfg_data carries the value; cfg_ready is always high. Writes must come only
// while no pulse is in flight; the block does not enforce it. Unknown indexes
// are ignored. A pulse passes the input register, then the result register.
// Throughput: one pulse per cycle while results are taken; the decode is a
// bank of window compares and a small phase update.
// Reset: timing registers return to their nominal NEC values, the decoder
// waits for a header mark, both stages are empty. No clearing pass.
// Stall: while the result register is full and not taken, the pending pulse
// stays in the input register and s_tready drops; nothing is lost.
`default_nettype none

module nec_ir_pulse_decoder_top
    import nipd_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Slave stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [19:0] pulse_us, [23:20] zero
    // Master stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // [0] frame_ready, [32:1] frame_data,
                                                // [33] in_error, [39:34] zero
    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [INDEX_W-1:0]   cfg_index,
    input  wire logic [GAP_W-1:0]     cfg_data
);

    cfg_t                cfg;
    logic                in_valid_reg;
    logic [PULSE_W-1:0]  pulse_reg;
    logic                step;
    logic                out_free;
    logic                out_take;
    result_t             result;

    assign cfg_ready = 1'b1;

    nipd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held pulse into the decoder when the result slot frees up
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;
    assign out_take = m_tvalid && m_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pulse_reg    <= '0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
            if (s_tvalid)
                pulse_reg <= s_tdata[PULSE_W-1:0];
        end
    end

    nipd_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .pulse_us  (pulse_reg),
        .out_take  (out_take),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .result    (result)
    );

    // Pack the result
    assign m_tdata = {(M_TDATA_W - WORD_W - 2)'(0), result.in_error,
                      result.frame_data, result.frame_ready};

    // A decoded pulse always lands in the result register
    a_step_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid
    ) else $error("decoded pulse did not produce a result");

    // A full pipeline with a stalled result must refuse new pulses
    a_no_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready
    ) else $error("input register overrun while output stalled");

    // A taken result with nothing behind it empties the result register
    a_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_take && !step) |=> !m_tvalid
    ) else $error("result register did not drain");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
    import nipd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int FRAME_PULSES   = 2 * FRAME_BITS_DEF + 4;
    localparam logic [PULSE_W-1:0] PULSE_MAX  = '1;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
    // largest deviation that still matches at the reset tolerance
    localparam int TOL_IN = TOLERANCE_RST - 1;

    typedef enum logic [2:0] {
        PH_WAIT_HDR_MARK,
        PH_WAIT_HDR_SPACE,
        PH_WAIT_BIT_MARK,
        PH_WAIT_BIT_SPACE,
        PH_WAIT_CLOSE,
        PH_FRAME_DONE,
        PH_ERROR
    } dec_phase_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_HOLD,
        RX_JITTER
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [INDEX_W-1:0]   cfg_index;
    logic [GAP_W-1:0]     cfg_data;

    // Decoder state mirrored by the testbench
    cfg_t              dec_cfg;
    dec_phase_t        dec_phase;
    logic [WORD_W-1:0] dec_word;
    logic [COUNT_W-1:0] dec_count;

    result_t     expected_results[$];
    int unsigned pulse_count;
    int unsigned closing_count;
    int unsigned good_frames;
    int unsigned error_pulses;
    int unsigned settings_count;
    int unsigned err_count;
    int unsigned idle_cycles;
    int unsigned tx_burst_left;
    int unsigned rx_left;
    rx_mode_t    rx_mode;

    nec_ir_pulse_decoder_top #(
        .FRAME_BITS (FRAME_BITS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [19:0] pulse_us, [23:20] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] frame_ready, [32:1] frame_data, [33] in_error
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Strict window compare against a nominal duration
    function automatic bit close_to(input logic [PULSE_W-1:0] d,
                                    input logic [NOM_W-1:0] nominal);
        int unsigned diff;
        diff = (d >= nominal) ? d - nominal : nominal - d;
        return diff < dec_cfg.tolerance_us;
    endfunction

    // Advance the mirrored decoder by one pulse and build its result
    function automatic result_t decode_pulse(input logic [PULSE_W-1:0] d);
        result_t     r;
        bit          advance;
        int unsigned next_count;
        r.frame_ready = 1'b0;
        advance = 1'b0;
        if (d > dec_cfg.reset_gap_us) begin
            dec_phase = PH_WAIT_HDR_MARK;
        end
        else begin
            case (dec_phase)
                PH_WAIT_HDR_MARK:
                    dec_phase = close_to(d, dec_cfg.header_mark_us) ? PH_WAIT_HDR_SPACE
                                                                     : PH_ERROR;
                PH_WAIT_HDR_SPACE:
                begin
                    if (close_to(d, dec_cfg.header_space_us)) begin
                        dec_word  = '0;
                        dec_count = '0;
                        dec_phase = PH_WAIT_BIT_MARK;
                    end
                    else begin
                        dec_phase = PH_ERROR;
                    end
                end
                PH_WAIT_BIT_MARK:
                    dec_phase = close_to(d, dec_cfg.bit_mark_us) ? PH_WAIT_BIT_SPACE : PH_ERROR;
                PH_WAIT_BIT_SPACE:
                begin
                    // zero wins when both windows overlap
                    if (close_to(d, dec_cfg.zero_space_us)) begin
                        if (dec_count < WORD_W)
                            dec_word[dec_count] = 1'b0;
                        advance = 1'b1;
                    end
                    else if (close_to(d, dec_cfg.one_space_us)) begin
                        if (dec_count < WORD_W)
                            dec_word[dec_count] = 1'b1;
                        advance = 1'b1;
                    end
                    else begin
                        dec_phase = PH_ERROR;
                    end
                    if (advance) begin
                        next_count = dec_count + 1;
                        dec_count  = next_count[COUNT_W-1:0];
                        dec_phase  = (next_count == FRAME_BITS_DEF) ? PH_WAIT_CLOSE
                                                                    : PH_WAIT_BIT_MARK;
                    end
                end
                PH_WAIT_CLOSE:
                begin
                    // ready is flagged whether or not the closing mark fits
                    r.frame_ready = 1'b1;
                    closing_count++;
                    if (close_to(d, dec_cfg.bit_mark_us)) begin
                        dec_phase = PH_FRAME_DONE;
                        good_frames++;
                    end
                    else begin
                        dec_phase = PH_ERROR;
                    end
                end
                default:
                    dec_phase = PH_ERROR;
            endcase
        end
        r.frame_data = dec_word;
        r.in_error   = (dec_phase == PH_ERROR);
        if (r.in_error)
            error_pulses++;
        return r;
    endfunction

    function automatic void apply_reg(input logic [INDEX_W-1:0] idx,
                                      input logic [GAP_W-1:0] data);
        case (idx)
            REG_TOLERANCE:    dec_cfg.tolerance_us    = data[NOM_W-1:0];
            REG_HEADER_MARK:  dec_cfg.header_mark_us  = data[NOM_W-1:0];
            REG_HEADER_SPACE: dec_cfg.header_space_us = data[NOM_W-1:0];
            REG_BIT_MARK:     dec_cfg.bit_mark_us     = data[NOM_W-1:0];
            REG_ZERO_SPACE:   dec_cfg.zero_space_us   = data[NOM_W-1:0];
            REG_ONE_SPACE:    dec_cfg.one_space_us    = data[NOM_W-1:0];
            REG_RESET_GAP:    dec_cfg.reset_gap_us    = data;
            default: ;
        endcase
    endfunction

    // Nominal plus a deviation that stays inside the window
    function automatic logic [PULSE_W-1:0] jittered(input int unsigned nominal);
        int unsigned tol;
        int unsigned j;
        int          v;
        tol = dec_cfg.tolerance_us;
        if (tol == 0)
            j = 0;
        else if ($urandom_range(0, 7) == 0)
            j = tol - 1;
        else
            j = $urandom_range(0, tol - 1);
        v = $urandom_range(0, 1) ? int'(nominal) + int'(j) : int'(nominal) - int'(j);
        if (v < 0)
            v = 0;
        return v[PULSE_W-1:0];
    endfunction

    // A pulse that is likely off: random, window edge, long or zero
    function automatic logic [PULSE_W-1:0] odd_pulse(input int unsigned nominal);
        int unsigned v;
        int unsigned tol;
        tol = dec_cfg.tolerance_us;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, PULSE_MAX);
            1: v = $urandom_range(0, 3000);
            2: v = (nominal >= tol && $urandom_range(0, 1)) ? nominal - tol : nominal + tol;
            3: v = dec_cfg.reset_gap_us + 1;
            default: v = 0;
        endcase
        if (v > PULSE_MAX)
            v = PULSE_MAX;
        return v[PULSE_W-1:0];
    endfunction

    // Transfer one pulse in bursts with random gaps, then record its result
    task automatic send_pulse(input logic [PULSE_W-1:0] d);
        logic took;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
        tx_burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-PULSE_W){1'b0}}, d};
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        expected_results.push_back(decode_pulse(d));
        pulse_count++;
    endtask

    // Drop valid and hold until every result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [GAP_W-1:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        apply_reg(idx, data);
    endtask

    // Write every timing register while the decoder is idle
    task automatic load_settings(input cfg_t c, input bit with_unused);
        logic [3:0]       hi;
        logic [GAP_W-1:0] junk;
        // park the decoder in header wait when a long pulse is possible
        if (dec_cfg.reset_gap_us != PULSE_MAX)
            send_pulse(PULSE_MAX);
        wait_drained();
        if (with_unused) begin
            junk = GAP_W'($urandom_range(0, PULSE_MAX));
            write_reg(REG_UNUSED, junk);
        end
        // upper bits of the 16-bit registers carry noise that must be dropped
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_TOLERANCE, {hi, c.tolerance_us});
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_HEADER_MARK, {hi, c.header_mark_us});
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_HEADER_SPACE, {hi, c.header_space_us});
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_BIT_MARK, {hi, c.bit_mark_us});
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_ZERO_SPACE, {hi, c.zero_space_us});
        hi = 4'($urandom_range(0, 15));
        write_reg(REG_ONE_SPACE, {hi, c.one_space_us});
        write_reg(REG_RESET_GAP, c.reset_gap_us);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // One frame: resync pulse, header, bit pairs, closing mark
    task automatic send_frame(input bit corrupt);
        logic [PULSE_W-1:0] seq [FRAME_PULSES];
        int unsigned        nom [FRAME_PULSES];
        logic [WORD_W-1:0]  bits;
        int unsigned        sync;
        int unsigned        pos;
        bits = $urandom();
        sync = dec_cfg.reset_gap_us + 1 + $urandom_range(0, 1000);
        seq[0] = (sync > PULSE_MAX) ? PULSE_MAX : sync[PULSE_W-1:0];
        nom[0] = dec_cfg.reset_gap_us;
        nom[1] = dec_cfg.header_mark_us;
        nom[2] = dec_cfg.header_space_us;
        for (int i = 0; i < FRAME_BITS_DEF; i++) begin
            nom[3 + 2 * i] = dec_cfg.bit_mark_us;
            nom[4 + 2 * i] = bits[i] ? dec_cfg.one_space_us : dec_cfg.zero_space_us;
        end
        nom[FRAME_PULSES - 1] = dec_cfg.bit_mark_us;
        for (int i = 1; i < FRAME_PULSES; i++)
            seq[i] = jittered(nom[i]);
        if (corrupt) begin
            pos = $urandom_range(1, FRAME_PULSES - 1);
            seq[pos] = odd_pulse(nom[pos]);
        end
        for (int i = 0; i < FRAME_PULSES; i++)
            send_pulse(seq[i]);
    endtask

    // Mostly clean frames, some broken frames and short noise bursts
    task automatic run_traffic(input int unsigned n_items);
        int unsigned first;
        int unsigned nom;
        first = pulse_count;
        while (pulse_count - first < n_items) begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(0, 2))
                            0:       nom = dec_cfg.header_mark_us;
                            1:       nom = dec_cfg.bit_mark_us;
                            default: nom = dec_cfg.one_space_us;
                        endcase
                        send_pulse(odd_pulse(nom));
                    end
                end
                1, 2:    send_frame(1'b1);
                default: send_frame(1'b0);
            endcase
        end
    endtask

    // Edges of the pulse field, window edges and the header space repair
    task automatic test_directed_defaults();
        send_pulse(PULSE_MAX);
        send_pulse('0);
        send_pulse(RESET_GAP_RST);
        send_pulse(PULSE_W'(RESET_GAP_RST + 1));
        send_pulse(PULSE_W'(HEADER_MARK_RST - TOL_IN));
        send_pulse(PULSE_W'(HEADER_SPACE_RST + TOL_IN));
        send_pulse(PULSE_W'(BIT_MARK_RST));
        send_pulse(PULSE_W'(ONE_SPACE_RST));
        send_pulse(PULSE_W'(BIT_MARK_RST - TOL_IN));
        send_pulse(PULSE_W'(ZERO_SPACE_RST + TOL_IN));
        send_pulse(PULSE_W'(BIT_MARK_RST));
        send_pulse(PULSE_W'(ONE_SPACE_RST + TOLERANCE_RST));
        send_pulse(20'h55555);
        send_pulse(20'hAAAAA);
        send_pulse(PULSE_W'(HEADER_MARK_RST + TOLERANCE_RST));
        send_pulse(PULSE_W'(RESET_GAP_RST + 1));
        send_pulse(PULSE_W'(HEADER_MARK_RST));
        // a wrong header space must end in the error phase
        send_pulse(PULSE_W'(HEADER_SPACE_RST - TOLERANCE_RST));
        send_pulse(PULSE_W'(RESET_GAP_RST + 1));
        send_pulse(PULSE_W'(HEADER_MARK_RST));
        send_pulse(PULSE_W'(HEADER_SPACE_RST));
        send_pulse(PULSE_W'(BIT_MARK_RST));
        send_pulse(20'd3000);
    endtask

    task automatic test_default_frames();
        run_traffic(400);
    endtask

    task automatic test_overlapping_spaces();
        cfg_t c;
        c = dec_cfg;
        c.tolerance_us  = 200;
        c.zero_space_us = 600;
        c.one_space_us  = 700;
        load_settings(c, 1'b0);
        run_traffic(300);
    endtask

    task automatic test_zero_tolerance();
        cfg_t c;
        c = dec_cfg;
        c.tolerance_us = '0;
        load_settings(c, 1'b1);
        run_traffic(150);
    endtask

    task automatic test_min_reset_gap();
        cfg_t c;
        c.tolerance_us    = TOLERANCE_RST;
        c.header_mark_us  = HEADER_MARK_RST;
        c.header_space_us = HEADER_SPACE_RST;
        c.bit_mark_us     = BIT_MARK_RST;
        c.zero_space_us   = ZERO_SPACE_RST;
        c.one_space_us    = ONE_SPACE_RST;
        c.reset_gap_us    = '0;
        load_settings(c, 1'b0);
        run_traffic(100);
    endtask

    task automatic test_extreme_nominals();
        cfg_t c;
        c.tolerance_us    = 3000;
        c.header_mark_us  = '1;
        c.header_space_us = '0;
        c.bit_mark_us     = '0;
        c.zero_space_us   = '0;
        c.one_space_us    = '1;
        c.reset_gap_us    = PULSE_MAX - 1'b1;
        load_settings(c, 1'b0);
        run_traffic(150);
    endtask

    task automatic test_random_settings();
        cfg_t        c;
        int unsigned top;
        repeat (2) begin
            c.tolerance_us    = NOM_W'($urandom_range(1, 1500));
            c.header_mark_us  = NOM_W'($urandom_range(2000, 20000));
            c.header_space_us = NOM_W'($urandom_range(1000, 10000));
            c.bit_mark_us     = NOM_W'($urandom_range(100, 2000));
            c.zero_space_us   = NOM_W'($urandom_range(100, 2000));
            c.one_space_us    = NOM_W'($urandom_range(100, 4000));
            top = c.header_mark_us;
            if (c.header_space_us > top)
                top = c.header_space_us;
            c.reset_gap_us = GAP_W'(top + $urandom_range(1, 40000));
            load_settings(c, 1'($urandom_range(0, 1)));
            run_traffic(250);
        end
    endtask

    // Every window as wide as possible and no pulse counts as long
    task automatic test_wide_tolerance();
        cfg_t c;
        c = dec_cfg;
        c.tolerance_us = '1;
        c.reset_gap_us = PULSE_MAX;
        load_settings(c, 1'b0);
        run_traffic(150);
    endtask

    task automatic test_restore_defaults();
        cfg_t c;
        c.tolerance_us    = TOLERANCE_RST;
        c.header_mark_us  = HEADER_MARK_RST;
        c.header_space_us = HEADER_SPACE_RST;
        c.bit_mark_us     = BIT_MARK_RST;
        c.zero_space_us   = ZERO_SPACE_RST;
        c.one_space_us    = ONE_SPACE_RST;
        c.reset_gap_us    = RESET_GAP_RST;
        load_settings(c, 1'b1);
        run_traffic(200);
    endtask

    // Receiver: steady runs, hard stalls and per-cycle random ready
    always @(posedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = (rx_mode == RX_STEADY) ? $urandom_range(1, 60) : $urandom_range(1, 12);
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_HOLD:   m_tready <= 1'b0;
            default:   m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Compare each result transfer with the oldest prediction
    always @(negedge clk)
    begin : check_result
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: result with nothing expected, got %h", $time, m_tdata);
            end
            else begin
                want = expected_results.pop_front();
                if (got.frame_ready !== want.frame_ready) begin
                    err_count++;
                    $display("%0t: frame_ready expected %b, got %b",
                             $time, want.frame_ready, got.frame_ready);
                end
                if (got.frame_data !== want.frame_data) begin
                    err_count++;
                    $display("%0t: frame_data expected %h, got %h",
                             $time, want.frame_data, got.frame_data);
                end
                if (got.in_error !== want.in_error) begin
                    err_count++;
                    $display("%0t: in_error expected %b, got %b",
                             $time, want.in_error, got.in_error);
                end
            end
        end
    end

    // Abort when no transfer happens on any channel for too long
    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TOLERANCE;
        cfg_data  = '0;
        dec_cfg.tolerance_us    = TOLERANCE_RST;
        dec_cfg.header_mark_us  = HEADER_MARK_RST;
        dec_cfg.header_space_us = HEADER_SPACE_RST;
        dec_cfg.bit_mark_us     = BIT_MARK_RST;
        dec_cfg.zero_space_us   = ZERO_SPACE_RST;
        dec_cfg.one_space_us    = ONE_SPACE_RST;
        dec_cfg.reset_gap_us    = RESET_GAP_RST;
        dec_phase      = PH_WAIT_HDR_MARK;
        dec_word       = '0;
        dec_count      = '0;
        pulse_count    = 0;
        closing_count  = 0;
        good_frames    = 0;
        error_pulses   = 0;
        settings_count = 0;
        err_count      = 0;
        idle_cycles    = 0;
        tx_burst_left  = 0;
        rx_left        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_defaults();
        test_default_frames();
        test_overlapping_spaces();
        test_zero_tolerance();
        test_min_reset_gap();
        test_extreme_nominals();
        test_random_settings();
        test_wide_tolerance();
        test_restore_defaults();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d pulses under reset timing and %0d written timing sets.",
                 pulse_count, settings_count);
        $display("Saw %0d closing pulses, %0d clean frames, %0d error-phase results.",
                 closing_count, good_frames, error_pulses);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
